### sv/qfsp_pkg.sv
// ----------------------------------------------------------------------------
// qfsp_pkg: shared types and constants for the QPACK field section parser
// Result kinds, error codes, parse phases and static table length ROMs.
// ----------------------------------------------------------------------------
`default_nettype none
package qfsp_pkg;

  localparam int unsigned STATIC_ENTRIES = 99;

  typedef enum logic [2:0] {
    KIND_STATIC  = 3'd0,
    KIND_NAMEREF = 3'd1,
    KIND_NAME    = 3'd2,
    KIND_VALUE   = 3'd3,
    KIND_ERROR   = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    ERR_INSERT_COUNT = 4'd0,
    ERR_TRUNC_PREFIX = 4'd1,
    ERR_DYN_INDEXED  = 4'd2,
    ERR_INDEX_RANGE  = 4'd3,
    ERR_DYN_NAMEREF  = 4'd4,
    ERR_TRUNCATED    = 4'd5,
    ERR_STRING_LIMIT = 4'd6,
    ERR_LIST_LIMIT   = 4'd7,
    ERR_PB_INDEXED   = 4'd8,
    ERR_PB_NAMEREF   = 4'd9,
    ERR_INT_OVERFLOW = 4'd10
  } err_t;

  // Kept in the same order as the prefix/line flow (prefix phases lowest).
  typedef enum logic [11:0] {
    PH_RIC    = 12'b0000_0000_0001,
    PH_RIC_C  = 12'b0000_0000_0010,
    PH_BASE   = 12'b0000_0000_0100,
    PH_BASE_C = 12'b0000_0000_1000,
    PH_LINE   = 12'b0000_0001_0000,
    PH_IDX    = 12'b0000_0010_0000,
    PH_REF    = 12'b0000_0100_0000,
    PH_NLEN   = 12'b0000_1000_0000,
    PH_NAME   = 12'b0001_0000_0000,
    PH_VHDR   = 12'b0010_0000_0000,
    PH_VLEN   = 12'b0100_0000_0000,
    PH_VALUE  = 12'b1000_0000_0000
  } phase_t;

  typedef struct packed {
    kind_t      kind;
    logic [6:0] static_index;
    logic [7:0] text_byte;
    logic       huffman_coded;
    logic       line_end;
    logic       section_end;
    err_t       error_code;
  } result_t;

  function automatic logic [5:0] name_len(input logic [6:0] idx);
    logic [5:0] r;
    r = 6'd0;
    case (idx)
      7'd0: r = 6'd10; 7'd1: r = 6'd5; 7'd2: r = 6'd3; 7'd3: r = 6'd19;
      7'd4: r = 6'd14; 7'd5: r = 6'd6; 7'd6: r = 6'd4; 7'd7: r = 6'd4;
      7'd8: r = 6'd17; 7'd9: r = 6'd13; 7'd10: r = 6'd13; 7'd11: r = 6'd4;
      7'd12: r = 6'd8; 7'd13: r = 6'd7; 7'd14: r = 6'd10;
      7'd15, 7'd16, 7'd17, 7'd18, 7'd19, 7'd20, 7'd21, 7'd22, 7'd23, 7'd24,
      7'd25, 7'd26, 7'd27, 7'd28: r = 6'd7;
      7'd29, 7'd30: r = 6'd6; 7'd31: r = 6'd15; 7'd32: r = 6'd13;
      7'd33, 7'd34: r = 6'd28; 7'd35: r = 6'd27;
      7'd36, 7'd37, 7'd38, 7'd39, 7'd40, 7'd41: r = 6'd13;
      7'd42, 7'd43: r = 6'd16;
      7'd44, 7'd45, 7'd46, 7'd47, 7'd48, 7'd49, 7'd50, 7'd51, 7'd52, 7'd53,
      7'd54: r = 6'd12;
      7'd55: r = 6'd5; 7'd56, 7'd57, 7'd58: r = 6'd25; 7'd59, 7'd60: r = 6'd4;
      7'd61: r = 6'd22; 7'd62: r = 6'd16;
      7'd63, 7'd64, 7'd65, 7'd66, 7'd67, 7'd68, 7'd69, 7'd70, 7'd71: r = 6'd7;
      7'd72: r = 6'd15; 7'd73, 7'd74: r = 6'd32;
      7'd75, 7'd76, 7'd77, 7'd78: r = 6'd28; 7'd79: r = 6'd29; 7'd80: r = 6'd30;
      7'd81, 7'd82: r = 6'd29; 7'd83: r = 6'd7; 7'd84: r = 6'd13;
      7'd85: r = 6'd23; 7'd86: r = 6'd10; 7'd87, 7'd88: r = 6'd9;
      7'd89: r = 6'd8; 7'd90: r = 6'd6; 7'd91: r = 6'd7; 7'd92: r = 6'd6;
      7'd93: r = 6'd19; 7'd94: r = 6'd25; 7'd95: r = 6'd10;
      7'd96, 7'd97, 7'd98: r = 6'd15;
      default: r = 6'd0;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] value_len(input logic [6:0] idx);
    logic [5:0] r;
    r = 6'd0;
    case (idx)
      7'd1, 7'd2, 7'd4, 7'd35, 7'd75, 7'd86, 7'd93, 7'd94: r = 6'd1;
      7'd15, 7'd19: r = 6'd7; 7'd16: r = 6'd6;
      7'd17, 7'd21, 7'd24, 7'd25, 7'd26, 7'd27, 7'd28, 7'd29, 7'd63, 7'd64,
      7'd65, 7'd66, 7'd67, 7'd68, 7'd69, 7'd70, 7'd71, 7'd76, 7'd81: r = 6'd3;
      7'd18, 7'd20, 7'd22, 7'd43, 7'd74, 7'd82, 7'd97: r = 6'd4;
      7'd23, 7'd32, 7'd73, 7'd83: r = 6'd5;
      7'd30, 7'd44, 7'd52: r = 6'd23; 7'd31: r = 6'd17;
      7'd33, 7'd62: r = 6'd13; 7'd34, 7'd80: r = 6'd12;
      7'd36, 7'd48, 7'd50: r = 6'd9; 7'd37, 7'd59: r = 6'd15;
      7'd38, 7'd79: r = 6'd14; 7'd39, 7'd40, 7'd51, 7'd55, 7'd91: r = 6'd8;
      7'd41, 7'd54: r = 6'd24; 7'd42: r = 6'd2; 7'd45: r = 6'd22;
      7'd46, 7'd56: r = 6'd16; 7'd47: r = 6'd33; 7'd49, 7'd53, 7'd98: r = 6'd10;
      7'd57: r = 6'd34; 7'd58: r = 6'd42; 7'd60: r = 6'd6; 7'd61, 7'd78: r = 6'd7;
      7'd77: r = 6'd18; 7'd85: r = 6'd51;
      default: r = 6'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### sv/qfsp_if.sv
// ----------------------------------------------------------------------------
// qfsp_in_if / qfsp_out_if: valid/ready word channels
// Input carries one section octet; output carries one parse result.
// ----------------------------------------------------------------------------
`default_nettype none
interface qfsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] block_byte;
  logic       block_last;
  modport source (output valid, block_byte, block_last, input ready);
  modport sink   (input valid, block_byte, block_last, output ready);
endinterface

interface qfsp_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [6:0] static_index;
  logic [7:0] text_byte;
  logic       huffman_coded;
  logic       line_end;
  logic       section_end;
  logic [3:0] error_code;
  modport source (output valid, kind, static_index, text_byte, huffman_coded,
                  line_end, section_end, error_code, input ready);
  modport sink   (input valid, kind, static_index, text_byte, huffman_coded,
                  line_end, section_end, error_code, output ready);
endinterface
`default_nettype wire

### sv/qfsp_core.sv
// ----------------------------------------------------------------------------
// qfsp_core: per-octet parse step
// Holds the parse state and turns one octet into at most one result.
// ----------------------------------------------------------------------------
`default_nettype none
module qfsp_core #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                step,
  input  wire logic [7:0]          b,
  input  wire logic                last,
  input  wire logic [31:0]         limit,
  output qfsp_pkg::result_t        res,
  output logic                     res_valid
);
  localparam logic [61:0] INT62_MAX = {62{1'b1}};
  localparam logic [61:0] LEN_MAX   = 62'((64'd1 << LENGTH_BITS) - 64'd1);

  qfsp_pkg::phase_t phase_r, phase_nxt;
  logic [61:0] acc_r, acc_nxt;
  logic [5:0]  shift_r, shift_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] total_r, total_nxt;
  logic [31:0] nlen_r, nlen_nxt;
  logic        huff_r, huff_nxt;
  logic        err_r, err_nxt;
  logic [6:0]  lidx_r, lidx_nxt;
  logic        isref_r, isref_nxt;

  // Continuation add: 7 bits shifted into 62, overflow-checked
  logic [68:0] cont_sum;
  logic        cont_ovf;
  assign cont_sum = {7'd0, acc_r} + ({62'd0, b[6:0]} << shift_r);
  assign cont_ovf = (shift_r > 6'd56) || (cont_sum > {7'd0, INT62_MAX});

  logic [5:0]  rn, rv;
  logic [6:0]  vidx;
  logic [33:0] idx_sum;
  logic [63:0] vlen_sum;

  always_comb begin
    logic        done;
    logic        has_err;
    qfsp_pkg::err_t ecode;
    logic        n;
    logic        lend;
    logic [61:0] v;
    done    = 1'b0;
    has_err = 1'b0;
    ecode   = qfsp_pkg::ERR_INSERT_COUNT;
    n       = 1'b0;
    lend    = 1'b0;
    phase_nxt = phase_r; acc_nxt = acc_r; shift_nxt = shift_r; rem_nxt = rem_r;
    total_nxt = total_r; nlen_nxt = nlen_r; huff_nxt = huff_r; err_nxt = err_r;
    lidx_nxt = lidx_r; isref_nxt = isref_r;
    res = '{kind: qfsp_pkg::KIND_STATIC, static_index: 7'd0, text_byte: 8'd0,
            huffman_coded: 1'b0, line_end: 1'b0, section_end: 1'b0,
            error_code: qfsp_pkg::ERR_INSERT_COUNT};

    unique case (phase_r)
      qfsp_pkg::PH_RIC: begin
        acc_nxt = {54'd0, b}; shift_nxt = '0;
        done = (b != 8'hFF);
        if (!done) phase_nxt = qfsp_pkg::PH_RIC_C;
        else if (b != 8'd0) begin has_err = 1'b1; ecode = qfsp_pkg::ERR_INSERT_COUNT; end
        else phase_nxt = qfsp_pkg::PH_BASE;
      end
      qfsp_pkg::PH_RIC_C: begin
        if (cont_ovf) begin has_err = 1'b1; ecode = qfsp_pkg::ERR_INT_OVERFLOW; end
        else begin
          acc_nxt = cont_sum[61:0];
          if (b[7]) shift_nxt = shift_r + 6'd7;
          else if (cont_sum[61:0] != '0) begin
            has_err = 1'b1; ecode = qfsp_pkg::ERR_INSERT_COUNT;
          end else phase_nxt = qfsp_pkg::PH_BASE;
        end
      end
      qfsp_pkg::PH_BASE: begin
        acc_nxt = {55'd0, b[6:0]}; shift_nxt = '0;
        phase_nxt = (b[6:0] != 7'h7F) ? qfsp_pkg::PH_LINE : qfsp_pkg::PH_BASE_C;
      end
      qfsp_pkg::PH_BASE_C: begin
        if (cont_ovf) begin has_err = 1'b1; ecode = qfsp_pkg::ERR_INT_OVERFLOW; end
        else begin
          acc_nxt = cont_sum[61:0];
          if (b[7]) shift_nxt = shift_r + 6'd7;
          else phase_nxt = qfsp_pkg::PH_LINE;
        end
      end
      qfsp_pkg::PH_LINE: begin
        shift_nxt = '0;
        if (b[7]) begin
          if (!b[6]) begin has_err = 1'b1; ecode = qfsp_pkg::ERR_DYN_INDEXED; end
          else begin
            acc_nxt = {56'd0, b[5:0]}; done = (b[5:0] != 6'h3F);
            phase_nxt = qfsp_pkg::PH_IDX;
          end
        end else if (b[6]) begin
          if (!b[4]) begin has_err = 1'b1; ecode = qfsp_pkg::ERR_DYN_NAMEREF; end
          else begin
            acc_nxt = {58'd0, b[3:0]}; done = (b[3:0] != 4'hF);
            phase_nxt = qfsp_pkg::PH_REF;
          end
        end else if (b[5]) begin
          huff_nxt = b[3];
          acc_nxt = {59'd0, b[2:0]}; done = (b[2:0] != 3'h7);
          phase_nxt = qfsp_pkg::PH_NLEN;
        end else begin
          has_err = 1'b1;
          ecode = b[4] ? qfsp_pkg::ERR_PB_INDEXED : qfsp_pkg::ERR_PB_NAMEREF;
        end
      end
      qfsp_pkg::PH_IDX, qfsp_pkg::PH_REF, qfsp_pkg::PH_NLEN, qfsp_pkg::PH_VLEN: begin
        if (cont_ovf) begin has_err = 1'b1; ecode = qfsp_pkg::ERR_INT_OVERFLOW; end
        else begin
          acc_nxt = cont_sum[61:0];
          if (b[7]) shift_nxt = shift_r + 6'd7;
          else done = 1'b1;
        end
      end
      qfsp_pkg::PH_VHDR: begin
        huff_nxt = b[7];
        acc_nxt = {55'd0, b[6:0]}; shift_nxt = '0;
        done = (b[6:0] != 7'h7F);
        phase_nxt = qfsp_pkg::PH_VLEN;
      end
      qfsp_pkg::PH_NAME: begin
        n = 1'b1;
        res.kind = qfsp_pkg::KIND_NAME; res.text_byte = b; res.huffman_coded = huff_r;
        rem_nxt = rem_r - 32'd1;
        if (rem_r == 32'd1) phase_nxt = qfsp_pkg::PH_VHDR;
      end
      qfsp_pkg::PH_VALUE: begin
        n = 1'b1;
        rem_nxt = rem_r - 32'd1;
        lend = (rem_r == 32'd1);
        res.kind = qfsp_pkg::KIND_VALUE; res.text_byte = b; res.huffman_coded = huff_r;
        res.line_end = lend;
        if (lend) phase_nxt = qfsp_pkg::PH_LINE;
      end
      default: phase_nxt = qfsp_pkg::PH_RIC;
    endcase

    v = acc_nxt;
    vidx = v[6:0];
    rn = qfsp_pkg::name_len(vidx);
    rv = qfsp_pkg::value_len(vidx);
    idx_sum = {2'd0, total_r} + {28'd0, rn} + {28'd0, rv};
    vlen_sum = {32'd0, total_r} + {32'd0, nlen_r} + {2'd0, v};

    if (!has_err && done) begin
      unique case (phase_nxt)
        qfsp_pkg::PH_IDX: begin
          if (v >= 62'(qfsp_pkg::STATIC_ENTRIES)) begin
            has_err = 1'b1; ecode = qfsp_pkg::ERR_INDEX_RANGE;
          end else if (idx_sum > {2'd0, limit}) begin
            has_err = 1'b1; ecode = qfsp_pkg::ERR_LIST_LIMIT;
          end else begin
            total_nxt = idx_sum[31:0];
            n = 1'b1; lend = 1'b1;
            res.kind = qfsp_pkg::KIND_STATIC; res.static_index = vidx;
            res.line_end = 1'b1;
            phase_nxt = qfsp_pkg::PH_LINE;
          end
        end
        qfsp_pkg::PH_REF: begin
          if (v >= 62'(qfsp_pkg::STATIC_ENTRIES)) begin
            has_err = 1'b1; ecode = qfsp_pkg::ERR_INDEX_RANGE;
          end else begin
            lidx_nxt = vidx; nlen_nxt = {26'd0, rn}; isref_nxt = 1'b1;
            phase_nxt = qfsp_pkg::PH_VHDR;
          end
        end
        qfsp_pkg::PH_NLEN: begin
          if (v > {30'd0, limit} || v > LEN_MAX) begin
            has_err = 1'b1; ecode = qfsp_pkg::ERR_STRING_LIMIT;
          end else begin
            nlen_nxt = v[31:0]; rem_nxt = v[31:0]; isref_nxt = 1'b0;
            phase_nxt = (v != '0) ? qfsp_pkg::PH_NAME : qfsp_pkg::PH_VHDR;
          end
        end
        qfsp_pkg::PH_VLEN: begin
          if (v > {30'd0, limit} || v > LEN_MAX) begin
            has_err = 1'b1; ecode = qfsp_pkg::ERR_STRING_LIMIT;
          end else if (vlen_sum > {32'd0, limit}) begin
            has_err = 1'b1; ecode = qfsp_pkg::ERR_LIST_LIMIT;
          end else begin
            total_nxt = vlen_sum[31:0]; rem_nxt = v[31:0];
            lend = (v == '0);
            if (isref_r) begin
              n = 1'b1;
              res.kind = qfsp_pkg::KIND_NAMEREF; res.static_index = lidx_r;
              res.huffman_coded = huff_nxt; res.line_end = lend;
            end else if (lend) begin
              n = 1'b1;
              res.kind = qfsp_pkg::KIND_VALUE; res.static_index = 7'd1;
              res.huffman_coded = huff_nxt; res.line_end = 1'b1;
            end
            phase_nxt = lend ? qfsp_pkg::PH_LINE : qfsp_pkg::PH_VALUE;
          end
        end
        default: ;
      endcase
    end

    if (!has_err && last && phase_nxt != qfsp_pkg::PH_LINE) begin
      has_err = 1'b1;
      ecode = (phase_nxt <= qfsp_pkg::PH_BASE_C) ? qfsp_pkg::ERR_TRUNC_PREFIX
                                                   : qfsp_pkg::ERR_TRUNCATED;
    end

    res_valid = 1'b0;
    if (err_r) begin
      // Skipping to end of section after an error
      phase_nxt = phase_r; acc_nxt = acc_r; shift_nxt = shift_r; rem_nxt = rem_r;
      total_nxt = total_r; nlen_nxt = nlen_r; huff_nxt = huff_r;
      lidx_nxt = lidx_r; isref_nxt = isref_r;
    end else if (has_err) begin
      res = '{kind: qfsp_pkg::KIND_ERROR, static_index: 7'd0, text_byte: 8'd0,
              huffman_coded: 1'b0, line_end: 1'b0, section_end: 1'b0,
              error_code: ecode};
      res_valid = 1'b1;
      err_nxt = 1'b1;
    end else begin
      res_valid = n;
      res.section_end = last && n && lend;
    end

    if (last) begin
      phase_nxt = qfsp_pkg::PH_RIC; acc_nxt = '0; shift_nxt = '0; rem_nxt = '0;
      total_nxt = '0; nlen_nxt = '0; huff_nxt = 1'b0; err_nxt = 1'b0;
      lidx_nxt = '0; isref_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= qfsp_pkg::PH_RIC; acc_r <= '0; shift_r <= '0; rem_r <= '0;
      total_r <= '0; nlen_r <= '0; huff_r <= 1'b0; err_r <= 1'b0;
      lidx_r <= '0; isref_r <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt; acc_r <= acc_nxt; shift_r <= shift_nxt; rem_r <= rem_nxt;
      total_r <= total_nxt; nlen_r <= nlen_nxt; huff_r <= huff_nxt; err_r <= err_nxt;
      lidx_r <= lidx_nxt; isref_r <= isref_nxt;
    end
  end
endmodule
`default_nettype wire

### sv/qpack_field_section_parser.sv
// ----------------------------------------------------------------------------
// qpack_field_section_parser: QPACK field section parser, static table only
// Parses one octet per word, streams name/value octets and static references.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                         | handshake
//  in_     | in  | block_byte, block_last                          | valid/ready
//  out_    | out | kind, static_index, text_byte, huffman_coded,   | valid/ready
//          |     | line_end, section_end, error_code               |
//  cfg_    | in  | max_list_bytes (32 bits)                        | write enable
//
// One word per cycle unless the output stalls: the input register feeds the parse
// step, which writes the result register in the same cycle the word advances.
// After a word is accepted it sits in the input register; its result is then
// written to the result register, from which it can be taken.
// The input stage moves only when the result register is empty or drained,
// so a stalled output holds one word in each stage.
// Synchronous active-low reset restores the prefix phase and a 65536 limit.
// ----------------------------------------------------------------------------
`default_nettype none
module qpack_field_section_parser #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  qfsp_in_if.sink          in_ch,
  qfsp_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata
);
  logic [31:0] limit_r;
  always_ff @(posedge clk) begin
    if (!rst_n) limit_r <= 32'd65536;
    else if (cfg_we) limit_r <= cfg_wdata;
  end

  // Input register
  logic       iv_r;
  logic [7:0] ib_r;
  logic       il_r;
  // Result register
  logic       ov_r;
  qfsp_pkg::result_t ores_r;

  logic adv;   // input register word enters the parse step
  assign adv = iv_r && (!ov_r || out_ch.ready);
  assign in_ch.ready = !iv_r || adv;

  qfsp_pkg::result_t res;
  logic res_valid;

  qfsp_core #(.LENGTH_BITS(LENGTH_BITS)) u_core (
    .clk(clk), .rst_n(rst_n), .step(adv), .b(ib_r), .last(il_r),
    .limit(limit_r), .res(res), .res_valid(res_valid)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
    end else if (in_ch.ready) begin
      iv_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      ib_r <= in_ch.block_byte;
      il_r <= in_ch.block_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= res_valid;
    end else if (out_ch.ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) ores_r <= res;
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.kind          = ores_r.kind;
  assign out_ch.static_index  = ores_r.static_index;
  assign out_ch.text_byte     = ores_r.text_byte;
  assign out_ch.huffman_coded = ores_r.huffman_coded;
  assign out_ch.line_end      = ores_r.line_end;
  assign out_ch.section_end   = ores_r.section_end;
  assign out_ch.error_code    = ores_r.error_code;
endmodule
`default_nettype wire

### tb/qpack_field_section_parser_test.sv
// ----------------------------------------------------------------------------
// qpack_field_section_parser_test: self-checking bench for the section parser
// Feeds encoded field sections one octet per word with random gaps on both
// channels, predicts every result in a scoreboard and checks it field by field.
// ----------------------------------------------------------------------------
module qpack_field_section_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Scoreboard: a private copy of the parse state, plus the queue of results
  // still owed by the DUT.
  class ParseScoreboard;
    qfsp_pkg::phase_t  ph;
    bit   [63:0] acc;
    int unsigned shf;
    bit   [31:0] str_left, total, name_len_h, limit;
    bit          str_huff, dead, line_ref;
    bit   [6:0]  line_idx;
    bit   [5:0]  nlen [99];
    bit   [5:0]  vlen [99];
    qfsp_pkg::result_t owed_q[$];
    int          mismatches, checked;

    function new();
      nlen = '{10, 5, 3, 19, 14, 6, 4, 4, 17, 13, 13, 4, 8, 7, 10, 7, 7, 7, 7, 7,
               7, 7, 7, 7, 7, 7, 7, 7, 7, 6, 6, 15, 13, 28, 28, 27, 13, 13, 13, 13,
               13, 13, 16, 16, 12, 12, 12, 12, 12, 12, 12, 12, 12, 12, 12, 5, 25,
               25, 25, 4, 4, 22, 16, 7, 7, 7, 7, 7, 7, 7, 7, 7, 15, 32, 32, 28, 28,
               28, 28, 29, 30, 29, 29, 7, 13, 23, 10, 9, 9, 8, 6, 7, 6, 19, 25, 10,
               15, 15, 15};
      vlen = '{0, 1, 1, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 7, 6, 3, 4, 7,
               4, 3, 4, 5, 3, 3, 3, 3, 3, 3, 23, 17, 5, 13, 12, 1, 9, 15, 14, 8,
               8, 24, 2, 4, 23, 22, 16, 33, 9, 10, 9, 8, 23, 10, 24, 8, 16, 34, 42,
               15, 6, 7, 13, 3, 3, 3, 3, 3, 3, 3, 3, 3, 0, 5, 4, 1, 3, 18, 7, 14,
               12, 3, 4, 5, 0, 51, 1, 0, 0, 0, 0, 8, 0, 1, 1, 0, 0, 4, 10};
      limit = 32'd65536;
      clear();
    endfunction

    function void clear();
      ph = qfsp_pkg::PH_RIC; acc = 0; shf = 0; str_left = 0; total = 0;
      name_len_h = 0; str_huff = 0; dead = 0; line_idx = 0; line_ref = 0;
    endfunction

    // first octet of a prefixed integer: 1 when complete
    function int int_first(bit [7:0] b, int nbits);
      bit [63:0] mask;
      mask = (64'd1 << nbits) - 1;
      acc = {56'd0, b} & mask;
      shf = 0;
      return (acc < mask) ? 1 : 0;
    endfunction

    // continuation octet: 1 complete, 0 more, -1 overflow
    function int int_next(bit [7:0] b);
      bit [63:0] sum;
      if (shf > 56) return -1;
      sum = acc + ({57'd0, b[6:0]} << shf);
      if (sum > 64'h3FFF_FFFF_FFFF_FFFF) return -1;
      acc = sum;
      if (b[7]) begin
        shf += 7;
        return 0;
      end
      return 1;
    endfunction

    function qfsp_pkg::result_t mk(qfsp_pkg::kind_t k, bit [6:0] idx, bit [7:0] t,
                                   bit h, bit le);
      qfsp_pkg::result_t r;
      r.kind = k; r.static_index = idx; r.text_byte = t; r.huffman_coded = h;
      r.line_end = le; r.section_end = 0; r.error_code = qfsp_pkg::ERR_INSERT_COUNT;
      return r;
    endfunction

    function void note_word(bit [7:0] b, bit last);
      qfsp_pkg::result_t r;
      bit        have, lend, fail;
      qfsp_pkg::err_t code;
      int        st;
      bit [63:0] v;
      have = 0; lend = 0; fail = 0; st = 0; code = qfsp_pkg::ERR_INSERT_COUNT;
      if (dead) begin
        if (last) clear();
        return;
      end
      case (ph)
        qfsp_pkg::PH_RIC, qfsp_pkg::PH_RIC_C: begin
          st = (ph == qfsp_pkg::PH_RIC) ? int_first(b, 8) : int_next(b);
          if (st < 0) begin fail = 1; code = qfsp_pkg::ERR_INT_OVERFLOW; end
          else if (st == 0) ph = qfsp_pkg::PH_RIC_C;
          else if (acc != 0) begin fail = 1; code = qfsp_pkg::ERR_INSERT_COUNT; end
          else ph = qfsp_pkg::PH_BASE;
        end
        qfsp_pkg::PH_BASE, qfsp_pkg::PH_BASE_C: begin
          st = (ph == qfsp_pkg::PH_BASE) ? int_first(b, 7) : int_next(b);
          if (st < 0) begin fail = 1; code = qfsp_pkg::ERR_INT_OVERFLOW; end
          else ph = st ? qfsp_pkg::PH_LINE : qfsp_pkg::PH_BASE_C;
        end
        qfsp_pkg::PH_LINE: begin
          if (b[7]) begin
            if (!b[6]) begin fail = 1; code = qfsp_pkg::ERR_DYN_INDEXED; end
            else begin st = int_first(b, 6); ph = qfsp_pkg::PH_IDX; end
          end else if (b[6]) begin
            if (!b[4]) begin fail = 1; code = qfsp_pkg::ERR_DYN_NAMEREF; end
            else begin st = int_first(b, 4); ph = qfsp_pkg::PH_REF; end
          end else if (b[5]) begin
            str_huff = b[3];
            st = int_first(b, 3); ph = qfsp_pkg::PH_NLEN;
          end else begin
            fail = 1;
            code = b[4] ? qfsp_pkg::ERR_PB_INDEXED : qfsp_pkg::ERR_PB_NAMEREF;
          end
        end
        qfsp_pkg::PH_IDX, qfsp_pkg::PH_REF, qfsp_pkg::PH_NLEN, qfsp_pkg::PH_VLEN: begin
          st = int_next(b);
          if (st < 0) begin fail = 1; code = qfsp_pkg::ERR_INT_OVERFLOW; end
        end
        qfsp_pkg::PH_VHDR: begin
          str_huff = b[7];
          st = int_first(b, 7); ph = qfsp_pkg::PH_VLEN;
        end
        qfsp_pkg::PH_NAME: begin
          r = mk(qfsp_pkg::KIND_NAME, 0, b, str_huff, 0); have = 1;
          str_left--;
          if (str_left == 0) ph = qfsp_pkg::PH_VHDR;
        end
        qfsp_pkg::PH_VALUE: begin
          str_left--;
          lend = (str_left == 0);
          r = mk(qfsp_pkg::KIND_VALUE, 0, b, str_huff, lend); have = 1;
          if (lend) ph = qfsp_pkg::PH_LINE;
        end
        default: ph = qfsp_pkg::PH_RIC;
      endcase

      // a prefixed integer just completed: act on it
      if (!fail && st == 1) begin
        v = acc;
        if (ph == qfsp_pkg::PH_IDX) begin
          if (v >= 99) begin fail = 1; code = qfsp_pkg::ERR_INDEX_RANGE; end
          else if ({32'd0, total} + nlen[v] + vlen[v] > {32'd0, limit}) begin
            fail = 1; code = qfsp_pkg::ERR_LIST_LIMIT;
          end else begin
            total += nlen[v] + vlen[v];
            r = mk(qfsp_pkg::KIND_STATIC, v[6:0], 0, 0, 1); have = 1; lend = 1;
            ph = qfsp_pkg::PH_LINE;
          end
        end else if (ph == qfsp_pkg::PH_REF) begin
          if (v >= 99) begin fail = 1; code = qfsp_pkg::ERR_INDEX_RANGE; end
          else begin
            line_idx = v[6:0]; name_len_h = nlen[v]; line_ref = 1;
            ph = qfsp_pkg::PH_VHDR;
          end
        end else if (ph == qfsp_pkg::PH_NLEN) begin
          if (v > {32'd0, limit}) begin fail = 1; code = qfsp_pkg::ERR_STRING_LIMIT; end
          else begin
            name_len_h = v[31:0]; str_left = v[31:0]; line_ref = 0;
            ph = (v != 0) ? qfsp_pkg::PH_NAME : qfsp_pkg::PH_VHDR;
          end
        end else if (ph == qfsp_pkg::PH_VLEN) begin
          if (v > {32'd0, limit}) begin fail = 1; code = qfsp_pkg::ERR_STRING_LIMIT; end
          else if ({32'd0, total} + name_len_h + v > {32'd0, limit}) begin
            fail = 1; code = qfsp_pkg::ERR_LIST_LIMIT;
          end else begin
            total = total + name_len_h + v[31:0];
            str_left = v[31:0];
            lend = (v == 0);
            if (line_ref) begin
              r = mk(qfsp_pkg::KIND_NAMEREF, line_idx, 0, str_huff, lend); have = 1;
            end else if (lend) begin
              // empty literal value: marked with index 1 and no octet
              r = mk(qfsp_pkg::KIND_VALUE, 1, 0, str_huff, 1); have = 1;
            end
            ph = (v != 0) ? qfsp_pkg::PH_VALUE : qfsp_pkg::PH_LINE;
          end
        end
      end

      // section ended inside a line or with the prefix still open
      if (!fail && last && ph != qfsp_pkg::PH_LINE) begin
        fail = 1;
        code = (ph <= qfsp_pkg::PH_BASE_C) ? qfsp_pkg::ERR_TRUNC_PREFIX
                                           : qfsp_pkg::ERR_TRUNCATED;
      end

      if (fail) begin
        r = mk(qfsp_pkg::KIND_ERROR, 0, 0, 0, 0);
        r.error_code = code;
        owed_q.push_back(r);
        if (last) clear(); else dead = 1;
        return;
      end
      if (last) begin
        if (have && lend) r.section_end = 1;
        clear();
      end
      if (have) owed_q.push_back(r);
    endfunction

    task report(string what);
      $display("[%0t] MISMATCH %s", $realtime, what);
      mismatches++;
    endtask

    task check_result(qfsp_pkg::result_t got);
      qfsp_pkg::result_t e;
      if (owed_q.size() == 0) begin
        report($sformatf("unexpected result kind=%0d", got.kind));
        return;
      end
      e = owed_q.pop_front();
      checked++;
      if (got.kind != e.kind)
        report($sformatf("kind got %0d want %0d", got.kind, e.kind));
      if (got.static_index != e.static_index)
        report($sformatf("static_index got %0d want %0d", got.static_index,
                         e.static_index));
      if (got.text_byte != e.text_byte)
        report($sformatf("text_byte got %02h want %02h", got.text_byte, e.text_byte));
      if (got.huffman_coded != e.huffman_coded)
        report($sformatf("huffman_coded got %0b want %0b", got.huffman_coded,
                         e.huffman_coded));
      if (got.line_end != e.line_end)
        report($sformatf("line_end got %0b want %0b", got.line_end, e.line_end));
      if (got.section_end != e.section_end)
        report($sformatf("section_end got %0b want %0b", got.section_end,
                         e.section_end));
      if (got.error_code != e.error_code)
        report($sformatf("error_code got %0d want %0d", got.error_code, e.error_code));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  qfsp_in_if  in_ch ();
  qfsp_out_if out_ch ();

  qpack_field_section_parser u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  ParseScoreboard sb = new();

  bit [8:0] word_q[$];     // pending words: {last, octet}
  bit [8:0] sec_q[$];      // section under construction
  bit       no_gaps;       // when set, neither side idles
  int       n_words, n_sections;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.block_byte = '0;
    in_ch.block_last = 1'b0;
    out_ch.ready = 1'b0;
  end

  // Sender: a word stays put until taken; a gap is only inserted between words.
  always @(posedge clk) begin
    bit [8:0] w;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_word(in_ch.block_byte, in_ch.block_last);
      if (!in_ch.valid || in_ch.ready) begin
        if (word_q.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 26)) begin
          w = word_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.block_byte <= w[7:0];
          in_ch.block_last <= w[8];
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure, every taken result goes to the scoreboard.
  always @(posedge clk) begin
    qfsp_pkg::result_t got;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.kind = qfsp_pkg::kind_t'(out_ch.kind);
        got.static_index = out_ch.static_index;
        got.text_byte = out_ch.text_byte;
        got.huffman_coded = out_ch.huffman_coded;
        got.line_end = out_ch.line_end;
        got.section_end = out_ch.section_end;
        got.error_code = qfsp_pkg::err_t'(out_ch.error_code);
        sb.check_result(got);
      end
      out_ch.ready <= no_gaps || ($urandom_range(0, 99) >= 26);
    end
  end

  // prefixed integer with an nbits-wide first field under the given flags
  task automatic put_int(bit [7:0] flags, int nbits, longint unsigned v);
    longint unsigned mask;
    mask = (64'd1 << nbits) - 1;
    if (v < mask) begin
      sec_q.push_back({1'b0, flags | v[7:0]});
    end else begin
      sec_q.push_back({1'b0, flags | mask[7:0]});
      v -= mask;
      while (v >= 128) begin
        sec_q.push_back({1'b0, 1'b1, v[6:0]});
        v >>= 7;
      end
      sec_q.push_back({1'b0, v[7:0]});
    end
  endtask

  task automatic put_bytes(int n);
    repeat (n) sec_q.push_back({1'b0, 8'($urandom_range(0, 255))});
  endtask

  task automatic put_value(int n, bit h);
    put_int({h, 7'd0}, 7, n);
    put_bytes(n);
  endtask

  // close the section under construction and queue it
  task automatic ship();
    if (sec_q.size() == 0) sec_q.push_back(9'h000);
    sec_q[sec_q.size() - 1][8] = 1'b1;
    foreach (sec_q[i]) word_q.push_back(sec_q[i]);
    n_words += sec_q.size();
    n_sections++;
    sec_q.delete();
  endtask

  task automatic put_prefix();
    sec_q.push_back(9'h000);
    sec_q.push_back(9'h000);
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (word_q.size() != 0 || in_ch.valid || sb.owed_q.size() != 0);
    // words that owe nothing may still be inside the two-stage pipe
    repeat (6) @(posedge clk);
  endtask

  task automatic set_limit(bit [31:0] v);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.limit = v;
  endtask

  task automatic rand_len(output int n);
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 60) : $urandom_range(0, 6);
  endtask

  task automatic rand_idx(output int idx);
    idx = ($urandom_range(0, 11) == 0) ? $urandom_range(99, 200) : $urandom_range(0, 98);
  endtask

  // Mostly well-formed sections with random content; some noise, bad forms
  // and sections cut short.
  task automatic rand_section();
    int  nl, idx, n, cut;
    bit  h;
    case ($urandom_range(0, 19))
      0: put_int(0, 8, $urandom_range(1, 400));
      1: begin
        sec_q.push_back(9'h000);
        put_int(8'h80, 7, $urandom_range(0, 500));
      end
      default: begin
        sec_q.push_back(9'h000);
        put_int(0, 7, $urandom_range(0, 3));
      end
    endcase
    nl = $urandom_range(0, 4);
    repeat (nl) begin
      case ($urandom_range(0, 10))
        0, 1, 2: begin
          rand_idx(idx);
          put_int(8'hC0, 6, idx);
        end
        3, 4, 5: begin
          rand_idx(idx);
          put_int(8'h50, 4, idx);
          rand_len(n);
          put_value(n, $urandom_range(0, 1));
        end
        6, 7, 8: begin
          h = $urandom_range(0, 1);
          rand_len(n);
          put_int({4'b0010, h, 3'd0}, 3, n);
          put_bytes(n);
          rand_len(n);
          put_value(n, $urandom_range(0, 1));
        end
        9: put_bytes(1);
        default: begin
          // oversized integer in an index field
          sec_q.push_back(9'h0FF);
          repeat (10) sec_q.push_back(9'h0FF);
        end
      endcase
    end
    if ($urandom_range(0, 9) == 0 && sec_q.size() > 1) begin
      cut = $urandom_range(1, sec_q.size() - 1);
      while (sec_q.size() > cut) void'(sec_q.pop_back());
    end
    ship();
  endtask

  initial begin
    int phase;
    bit [31:0] lim;
    no_gaps = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed, default limit ---
    // indexed: lowest and highest static entries (highest needs continuation)
    put_prefix(); put_int(8'hC0, 6, 0); put_int(8'hC0, 6, 98); ship();
    // name reference to entry 98 with a Huffman value of 3 octets
    put_prefix(); put_int(8'h50, 4, 98); put_value(3, 1); ship();
    // name reference with empty value, last line
    put_prefix(); put_int(8'h50, 4, 0); put_value(0, 0); ship();
    // empty literal name and empty value, then a Huffman name of 7 octets
    put_prefix(); put_int(8'h20, 3, 0); put_value(0, 0);
    sec_q.push_back(9'h02F); sec_q.push_back(9'h000);
    sec_q.push_back(9'h000); sec_q.push_back(9'h0FF); put_bytes(5);
    put_value(1, 0); ship();
    // section with nothing after the prefix
    put_prefix(); ship();
    // nonzero insert count
    sec_q.push_back(9'h001); sec_q.push_back(9'h000); sec_q.push_back(9'h0C1); ship();
    // prefix truncated inside the insert count
    sec_q.push_back(9'h0FF); ship();
    // base with sign bit, then dynamic indexed line
    sec_q.push_back(9'h000); sec_q.push_back(9'h0FF); sec_q.push_back(9'h001);
    sec_q.push_back(9'h080); sec_q.push_back(9'h0C1); ship();
    // dynamic name reference, post-base indexed, post-base name reference
    put_prefix(); sec_q.push_back(9'h040); ship();
    put_prefix(); sec_q.push_back(9'h010); ship();
    put_prefix(); sec_q.push_back(9'h000); ship();
    // index just out of range, indexed and name reference
    put_prefix(); put_int(8'hC0, 6, 99); ship();
    put_prefix(); put_int(8'h50, 4, 99); put_value(0, 0); ship();
    // integer overflow in an index
    put_prefix(); sec_q.push_back(9'h0FF); repeat (10) sec_q.push_back(9'h0FF); ship();
    // section ends inside a name
    put_prefix(); put_int(8'h20, 3, 3); put_bytes(2); ship();

    // --- tight limits: string and list checks ---
    set_limit(32'd20);
    put_prefix(); put_int(8'h20, 3, 21); put_bytes(21); put_value(0, 0); ship();
    put_prefix(); put_int(8'hC0, 6, 3); put_int(8'hC0, 6, 3); ship();
    put_prefix(); put_int(8'h20, 3, 20); put_bytes(20); put_value(0, 0); ship();
    set_limit(32'd0);
    put_prefix(); put_int(8'h20, 3, 0); put_value(0, 0); put_int(8'hC0, 6, 2); ship();
    set_limit(32'hFFFF_FFFF);
    put_prefix(); put_int(8'h20, 3, 64'hFFFF_FFFF); ship();
    put_prefix(); put_int(8'h20, 3, 64'h1_0000_0000); ship();

    // --- random sections across several limits ---
    phase = 0;
    while (n_words < 1450) begin
      case (phase % 6)
        0: lim = 32'd65536;
        1: lim = 32'd0;
        2: lim = $urandom_range(10, 120);
        3: lim = 32'hFFFF_FFFF;
        4: lim = $urandom_range(0, 40);
        default: lim = $urandom();
      endcase
      no_gaps = (phase == 3);
      set_limit(lim);
      repeat (12) rand_section();
      phase++;
    end
    no_gaps = 1'b0;
    wait_idle();
    repeat (10) @(posedge clk);

    $display("Ran %0d sections, %0d octets, %0d results checked, last limit %0d.",
             n_sections, n_words, sb.checked, sb.limit);
    if (sb.mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #5ms;
    $display("Timed out waiting for results");
    $display("Mismatches found");
    $finish;
  end

endmodule
